// ===== hdl/cbm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cbm_pkg
// Shared widths, codes, types and helpers of the circuit breaker monitor.
// ============================================================================
package cbm_pkg;

    // Internal tally and timer widths
    localparam int COUNT_BITS = 16;
    localparam int TIMER_BITS = 20;

    // Field widths
    localparam int ACTION_W    = 3;
    localparam int MODE_W      = 2;
    localparam int OUT_COUNT_W = 16;
    localparam int THRESH_W    = 16;
    localparam int TICKS_W     = 20;
    localparam int PROBE_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [PROBE_W-1:0]    PROBE_MAX = {PROBE_W{1'b1}};

    // Event codes
    localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SUCCESS = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FAILURE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REACH   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RESET   = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_THRESH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_TICKS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_NEED  = 2'd3;

    // Register reset values
    localparam logic [THRESH_W-1:0] RST_FAIL_THRESH = 16'd5;
    localparam logic [TICKS_W-1:0]  RST_OPEN_TICKS  = 20'd30000;
    localparam logic [TICKS_W-1:0]  RST_WIN_TICKS   = 20'd60000;
    localparam logic [PROBE_W-1:0]  RST_PROBE_NEED  = 8'd3;

    // Reported mode codes
    localparam logic [MODE_W-1:0] BRK_CLOSED = 2'd0;
    localparam logic [MODE_W-1:0] BRK_OPEN   = 2'd1;
    localparam logic [MODE_W-1:0] BRK_HALF   = 2'd2;

    typedef enum logic [2:0] {
        MODE_CLOSED = 3'b001,
        MODE_OPEN   = 3'b010,
        MODE_HALF   = 3'b100
    } mode_t;

    typedef struct packed {
        logic                   allow_request;
        logic [MODE_W-1:0]      breaker_mode;
        logic                   is_online;
        logic [OUT_COUNT_W-1:0] success_count;
        logic [OUT_COUNT_W-1:0] failure_count;
        logic                   opened_event;
        logic                   closed_event;
        logic                   half_open_event;
        logic                   link_up_event;
        logic                   link_down_event;
    } result_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] code;
        case (m)
            MODE_CLOSED: code = BRK_CLOSED;
            MODE_OPEN:   code = BRK_OPEN;
            MODE_HALF:   code = BRK_HALF;
            default:     code = BRK_CLOSED;
        endcase
        return code;
    endfunction

endpackage

// ===== hdl/cbm_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cbm channel interfaces
// Valid/ready channels for events, results and register writes.
// ============================================================================
interface cbm_evt_if;
    import cbm_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                link_online;

    modport source (output valid, action, link_online, input ready);
    modport sink   (input valid, action, link_online, output ready);
endinterface

interface cbm_res_if;
    import cbm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   allow_request;
    logic [MODE_W-1:0]      breaker_mode;
    logic                   is_online;
    logic [OUT_COUNT_W-1:0] success_count;
    logic [OUT_COUNT_W-1:0] failure_count;
    logic                   opened_event;
    logic                   closed_event;
    logic                   half_open_event;
    logic                   link_up_event;
    logic                   link_down_event;

    modport source (
        output valid, allow_request, breaker_mode, is_online, success_count,
               failure_count, opened_event, closed_event, half_open_event,
               link_up_event, link_down_event,
        input  ready
    );
    modport sink (
        input  valid, allow_request, breaker_mode, is_online, success_count,
               failure_count, opened_event, closed_event, half_open_event,
               link_up_event, link_down_event,
        output ready
    );
endinterface

interface cbm_cfg_if;
    import cbm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/circuit_breaker_monitor.sv =====
`timescale 1ns / 1ps
// An accepted event beat is held in the event register, then its result beat
// is held in the result register, where it waits until the result is taken.
// Throughput: one event per cycle, sustained, as long as results are taken.
// The rate is set by the single pass from the event register to the result
// register, which also updates all breaker state in the same cycle.
// Reset (rst_n low, asynchronous): breaker closed, link online, tallies and
// timers cleared, registers back to threshold 5, 30000/60000 ticks, 3 probes.
// ============================================================================
// circuit_breaker_monitor
// Closed / open / half-open breaker driven by tick, success, failure,
// reachability and manual-reset events; one result beat per event beat.
// ============================================================================
module circuit_breaker_monitor (
    input  logic          clk,
    input  logic          rst_n,
    cbm_evt_if.sink       evt,
    cbm_res_if.source     res,
    cbm_cfg_if.sink       cfg
);
    import cbm_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers: writes are always taken.
    // ------------------------------------------------------------------
    logic [THRESH_W-1:0] fail_thresh_reg;
    logic [TICKS_W-1:0]  open_ticks_reg;
    logic [TICKS_W-1:0]  win_ticks_reg;
    logic [PROBE_W-1:0]  probe_need_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_thresh_reg <= RST_FAIL_THRESH;
            open_ticks_reg  <= RST_OPEN_TICKS;
            win_ticks_reg   <= RST_WIN_TICKS;
            probe_need_reg  <= RST_PROBE_NEED;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FAIL_THRESH: fail_thresh_reg <= cfg.data[THRESH_W-1:0];
                REG_OPEN_TICKS:  open_ticks_reg  <= cfg.data[TICKS_W-1:0];
                REG_WIN_TICKS:   win_ticks_reg   <= cfg.data[TICKS_W-1:0];
                REG_PROBE_NEED:  probe_need_reg  <= cfg.data[PROBE_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The event register refills in the same cycle it drains,
    // and the result register takes a new beat while the old one leaves,
    // so a stall on the result side only backs up one stage at a time.
    // ------------------------------------------------------------------
    logic                in_valid_reg;
    logic [ACTION_W-1:0] action_reg;
    logic                link_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                proc_fire;

    assign proc_fire = in_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            in_valid_reg <= evt.valid;
        end
    end

    // Event payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            action_reg <= evt.action;
            link_reg   <= evt.link_online;
        end
    end

    // ------------------------------------------------------------------
    // Breaker state
    // ------------------------------------------------------------------
    mode_t                 mode_reg,    mode_next;
    logic                  online_reg,  online_next;
    logic [COUNT_BITS-1:0] succ_reg,    succ_next;
    logic [COUNT_BITS-1:0] fail_reg,    fail_next;
    logic [PROBE_W-1:0]    probe_reg,   probe_next;
    logic [TIMER_BITS-1:0] open_rem_reg, open_rem_next;
    logic                  armed_reg,   armed_next;
    logic [TIMER_BITS-1:0] win_el_reg,  win_el_next;
    result_t               res_next;

    // One pass over the event, in the order the breaker rules apply:
    // counters first, then mode transitions, then the threshold recheck.
    always_comb
    begin
        logic ev_open;
        logic ev_close;
        logic ev_half;
        logic ev_up;
        logic ev_down;
        logic do_trip;
        logic do_close;

        mode_next     = mode_reg;
        online_next   = online_reg;
        succ_next     = succ_reg;
        fail_next     = fail_reg;
        probe_next    = probe_reg;
        open_rem_next = open_rem_reg;
        armed_next    = armed_reg;
        win_el_next   = win_el_reg;
        ev_open       = 1'b0;
        ev_close      = 1'b0;
        ev_half       = 1'b0;
        ev_up         = 1'b0;
        ev_down       = 1'b0;
        do_trip       = 1'b0;
        do_close      = 1'b0;

        case (action_reg)
            ACT_TICK:
            begin
                // Open timer is served before the window.
                if (armed_reg)
                begin
                    if (open_rem_reg <= TIMER_BITS'(1))
                    begin
                        armed_next    = 1'b0;
                        open_rem_next = '0;
                        if (mode_reg == MODE_OPEN)
                        begin
                            mode_next  = MODE_HALF;
                            probe_next = '0;
                            ev_half    = 1'b1;
                        end
                    end
                    else
                    begin
                        open_rem_next = open_rem_reg - TIMER_BITS'(1);
                    end
                end
                win_el_next = win_el_reg + TIMER_BITS'(1);
                if (32'(win_el_next) >= 32'(win_ticks_reg))
                begin
                    win_el_next = '0;
                    succ_next   = '0;
                    fail_next   = '0;
                    // Counts are zero here: only a zero threshold trips.
                    if (mode_next == MODE_CLOSED &&
                        32'(fail_next) >= 32'(fail_thresh_reg))
                    begin
                        do_trip = 1'b1;
                    end
                end
            end
            ACT_SUCCESS:
            begin
                succ_next = (succ_reg == COUNT_MAX) ? succ_reg
                                                    : succ_reg + COUNT_BITS'(1);
                if (mode_reg == MODE_HALF)
                begin
                    if (probe_reg != PROBE_MAX)
                    begin
                        probe_next = probe_reg + PROBE_W'(1);
                    end
                    if (probe_next >= probe_need_reg)
                    begin
                        do_close = 1'b1;
                    end
                end
                else if (mode_reg == MODE_OPEN)
                begin
                    do_close = 1'b1;
                end
            end
            ACT_FAILURE:
            begin
                fail_next = (fail_reg == COUNT_MAX) ? fail_reg
                                                    : fail_reg + COUNT_BITS'(1);
                if (mode_reg == MODE_CLOSED)
                begin
                    do_trip = 32'(fail_next) >= 32'(fail_thresh_reg);
                end
                else
                begin
                    // Half-open trips; open just restarts its timer.
                    do_trip = 1'b1;
                end
            end
            ACT_REACH:
            begin
                if (link_reg != online_reg)
                begin
                    online_next = link_reg;
                    if (link_reg)
                    begin
                        ev_up = 1'b1;
                        if (mode_reg == MODE_OPEN)
                        begin
                            mode_next  = MODE_HALF;
                            probe_next = '0;
                            ev_half    = 1'b1;
                        end
                    end
                    else
                    begin
                        ev_down = 1'b1;
                        do_trip = (mode_reg != MODE_OPEN);
                    end
                end
            end
            ACT_RESET:
            begin
                do_close = (mode_reg != MODE_CLOSED);
            end
            default:
            begin
            end
        endcase

        // Close: clears counts, probes and the timer.
        if (do_close)
        begin
            mode_next     = MODE_CLOSED;
            probe_next    = '0;
            armed_next    = 1'b0;
            open_rem_next = '0;
            succ_next     = '0;
            fail_next     = '0;
            ev_close      = 1'b1;
        end

        // Every success rechecks the threshold once the mode has settled:
        // a closed breaker at or over it (lowered or zero) trips.
        if (action_reg == ACT_SUCCESS && mode_next == MODE_CLOSED &&
            32'(fail_next) >= 32'(fail_thresh_reg))
        begin
            do_trip = 1'b1;
        end

        // Trip: enter open (flagged only on a real change) and (re)start timer.
        if (do_trip)
        begin
            if (mode_next != MODE_OPEN)
            begin
                ev_open = 1'b1;
            end
            mode_next     = MODE_OPEN;
            open_rem_next = TIMER_BITS'(open_ticks_reg);
            armed_next    = 1'b1;
        end

        res_next.allow_request   = online_next && (mode_next != MODE_OPEN);
        res_next.breaker_mode    = mode_code(mode_next);
        res_next.is_online       = online_next;
        res_next.success_count   = OUT_COUNT_W'(succ_next);
        res_next.failure_count   = OUT_COUNT_W'(fail_next);
        res_next.opened_event    = ev_open;
        res_next.closed_event    = ev_close;
        res_next.half_open_event = ev_half;
        res_next.link_up_event   = ev_up;
        res_next.link_down_event = ev_down;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_CLOSED;
            online_reg   <= 1'b1;
            succ_reg     <= '0;
            fail_reg     <= '0;
            probe_reg    <= '0;
            open_rem_reg <= '0;
            armed_reg    <= 1'b0;
            win_el_reg   <= '0;
        end
        else if (proc_fire)
        begin
            mode_reg     <= mode_next;
            online_reg   <= online_next;
            succ_reg     <= succ_next;
            fail_reg     <= fail_next;
            probe_reg    <= probe_next;
            open_rem_reg <= open_rem_next;
            armed_reg    <= armed_next;
            win_el_reg   <= win_el_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            out_reg <= res_next;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.allow_request   = out_reg.allow_request;
    assign res.breaker_mode    = out_reg.breaker_mode;
    assign res.is_online       = out_reg.is_online;
    assign res.success_count   = out_reg.success_count;
    assign res.failure_count   = out_reg.failure_count;
    assign res.opened_event    = out_reg.opened_event;
    assign res.closed_event    = out_reg.closed_event;
    assign res.half_open_event = out_reg.half_open_event;
    assign res.link_up_event   = out_reg.link_up_event;
    assign res.link_down_event = out_reg.link_down_event;

endmodule

// ===== hdl/cbm_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cbm_checker
// Port-level checks of the circuit breaker monitor, bound to the top level.
// ============================================================================
module cbm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            evt_valid,
    input logic                            evt_ready,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [cbm_pkg::MODE_W-1:0]      breaker_mode,
    input logic [cbm_pkg::OUT_COUNT_W-1:0] success_count,
    input logic [cbm_pkg::OUT_COUNT_W-1:0] failure_count,
    input logic                            opened_event,
    input logic                            closed_event,
    input logic                            half_open_event
);
    import cbm_pkg::*;

    logic              in_beat;
    logic              out_beat;
    logic [2:0]        pend_reg;
    logic [2:0]        pend_next;
    logic [MODE_W-1:0] prev_mode_reg;

    assign in_beat  = evt_valid && evt_ready;
    assign out_beat = res_valid && res_ready;

    always_comb
    begin
        pend_next = pend_reg + {2'b0, in_beat} - {2'b0, out_beat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            prev_mode_reg <= BRK_CLOSED;
        end
        else
        begin
            pend_reg <= pend_next;
            if (out_beat)
            begin
                prev_mode_reg <= breaker_mode;
            end
        end
    end

    // Stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(breaker_mode) &&
            $stable(success_count) && $stable(failure_count))
        else $error("result beat changed while stalled");

    // At most two beats in flight, and no result without a pending event
    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd2 && (!res_valid || pend_reg != 3'd0))
        else $error("result beats do not match event beats");

    // Half-open is only entered from open
    a_half_from_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && half_open_event |-> breaker_mode == BRK_HALF &&
            prev_mode_reg == BRK_OPEN)
        else $error("half-open entered from a mode other than open");

    // Closing clears the window counts and needs a non-closed mode before
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && closed_event |-> prev_mode_reg != BRK_CLOSED &&
            success_count == '0 && failure_count == '0)
        else $error("close event without clearing or from closed");

    // A trip always leaves the breaker open
    a_open_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && opened_event |-> breaker_mode == BRK_OPEN)
        else $error("open event with breaker not open");

endmodule

bind circuit_breaker_monitor cbm_checker u_cbm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .evt_valid       (evt.valid),
    .evt_ready       (evt.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .breaker_mode    (res.breaker_mode),
    .success_count   (res.success_count),
    .failure_count   (res.failure_count),
    .opened_event    (res.opened_event),
    .closed_event    (res.closed_event),
    .half_open_event (res.half_open_event)
);
